/* design/temp_sensor_poll_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the temperature sensor poll sequencer
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TEMP_SENSOR_POLL_SEQUENCER_ASSERT_SVH
`define TEMP_SENSOR_POLL_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define TSPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tsps_pkg.sv */
// ----------------------------------------------------------------------------
// tsps_pkg
// Types and constants shared by the poll sequencer modules.
// ----------------------------------------------------------------------------
package tsps_pkg;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_WAITING = 2'd1,
    MODE_READING = 2'd2,
    MODE_ERROR   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_PROBE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_SLOW_POLLING  = 2'd0,
    CFG_RETRY_DELAY   = 2'd1,
    CFG_MAX_RETRIES   = 2'd2
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned RES_W      = 4;
  localparam int unsigned RETRY_W    = 8;
  localparam int unsigned WAIT_W     = 14;

  localparam logic [RES_W-1:0] RES_9  = 4'd9;
  localparam logic [RES_W-1:0] RES_10 = 4'd10;
  localparam logic [RES_W-1:0] RES_12 = 4'd12;

  localparam logic signed [TEMP_W-1:0] TEMP_DISCONNECTED = 12'sh810;

  localparam logic [WAIT_W-1:0] SLOW_EXTRA_MS = 14'd10000;

  // (750 >> (12 - res)) + 50 for res 9..12
  localparam logic [WAIT_W-1:0] CONV_WAIT_MS [4] = '{14'd143, 14'd237, 14'd425, 14'd800};

  localparam logic [CFG_DATA_W-1:0] RETRY_DELAY_RST = 16'd5000;
  localparam logic [RETRY_W-1:0]    MAX_RETRIES_RST = 8'd3;

  typedef struct packed {
    func_e                     func;
    logic [TIME_W-1:0]         now_ms;
    logic                      sensor_found;
    logic signed [TEMP_W-1:0]  reading;
  } in_item_t;

  typedef struct packed {
    mode_e                     mode;
    logic signed [TEMP_W-1:0]  temperature;
    logic [RES_W-1:0]          resolution_bits;
    logic                      start_conversion;
    logic                      write_resolution;
    logic [RETRY_W-1:0]        retry_count;
  } out_item_t;

  // pipeline control between stages
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctrl_t;

  function automatic logic [WAIT_W-1:0] conv_wait_ms(input logic [RES_W-1:0] res,
                                                     input logic slow);
    logic [1:0]        idx;
    logic [WAIT_W-1:0] w;
    if (res < RES_9) begin
      idx = 2'd0;
    end else if (res > RES_12) begin
      idx = 2'd3;
    end else begin
      idx = 2'(res - RES_9);
    end
    w = CONV_WAIT_MS[idx];
    return slow ? (w + SLOW_EXTRA_MS) : w;
  endfunction

endpackage

/* design/tsps_if.sv */
// ----------------------------------------------------------------------------
// tsps_if
// Valid/ready channel interfaces: command input, result output, register write.
// ----------------------------------------------------------------------------
interface tsps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] now_ms;
  logic        sensor_found;
  logic signed [11:0] reading;

  modport source (output valid, func, now_ms, sensor_found, reading, input ready);
  modport sink   (input valid, func, now_ms, sensor_found, reading, output ready);
endinterface

interface tsps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic signed [11:0] temperature;
  logic [3:0]  resolution_bits;
  logic        start_conversion;
  logic        write_resolution;
  logic [7:0]  retry_count;

  modport source (output valid, mode, temperature, resolution_bits, start_conversion,
                  write_resolution, retry_count, input ready);
  modport sink   (input valid, mode, temperature, resolution_bits, start_conversion,
                  write_resolution, retry_count, output ready);
endinterface

interface tsps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/tsps_in_reg.sv */
// ----------------------------------------------------------------------------
// tsps_in_reg
// Input register: captures one command transaction per cycle unless the result register stalls it.
// ----------------------------------------------------------------------------
module tsps_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  tsps_in_if.sink           in_i,
  input  logic              can_load_i,
  output tsps_pkg::stage_ctrl_t ctrl_o,
  output tsps_pkg::in_item_t    item_o
);
  import tsps_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     advance;
  logic     take;

  assign advance    = valid_q && can_load_i;
  assign in_i.ready = !valid_q || can_load_i;
  assign take       = in_i.valid && in_i.ready;
  assign valid_d    = take || (valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.func         <= func_e'(in_i.func);
      item_q.now_ms       <= in_i.now_ms;
      item_q.sensor_found <= in_i.sensor_found;
      item_q.reading      <= in_i.reading;
    end
  end

  assign ctrl_o.valid   = valid_q;
  assign ctrl_o.advance = advance;
  assign item_o         = item_q;

endmodule

/* design/tsps_core.sv */
// ----------------------------------------------------------------------------
// tsps_core
// Polling state, configuration registers and the per-command update.
// ----------------------------------------------------------------------------
module tsps_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tsps_cfg_if.sink              cfg_i,
  input  tsps_pkg::stage_ctrl_t ctrl_i,
  input  tsps_pkg::in_item_t    item_i,
  output tsps_pkg::out_item_t   res_o
);
  import tsps_pkg::*;

  // configuration
  logic                  slow_q, slow_d;
  logic [CFG_DATA_W-1:0] retry_delay_q;
  logic [RETRY_W-1:0]    max_retries_q;

  // state
  mode_e                     mode_q, mode_d;
  logic [TIME_W-1:0]         last_upd_q, last_upd_d;
  logic [TIME_W-1:0]         last_err_q, last_err_d;
  logic [RETRY_W-1:0]        retries_q, retries_d;
  logic [RES_W-1:0]          res_q, res_d;
  logic signed [TEMP_W-1:0]  temp_q, temp_d;

  logic                step;
  logic                conv, wres;
  logic [TIME_W-1:0]   upd_elapsed, err_elapsed;
  logic                conv_due, err_due;
  logic [RETRY_W-1:0]  retries_inc;
  logic                cfg_wr;

  assign step        = ctrl_i.advance;
  // register writes wait until no command is held
  assign cfg_i.ready = !ctrl_i.valid;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  assign upd_elapsed = item_i.now_ms - last_upd_q;
  assign err_elapsed = item_i.now_ms - last_err_q;
  assign conv_due    = upd_elapsed >= {{(TIME_W-WAIT_W){1'b0}}, conv_wait_ms(res_q, slow_q)};
  assign err_due     = (err_elapsed >= {{(TIME_W-CFG_DATA_W){1'b0}}, retry_delay_q})
                       && (retries_q < max_retries_q);
  assign retries_inc = retries_q + 8'd1;

  always_comb begin
    mode_d     = mode_q;
    last_upd_d = last_upd_q;
    last_err_d = last_err_q;
    retries_d  = retries_q;
    res_d      = res_q;
    temp_d     = temp_q;
    slow_d     = slow_q;
    conv       = 1'b0;
    wres       = 1'b0;
    case (item_i.func)
      FUNC_START: begin
        if (mode_q == MODE_STOPPED) begin
          mode_d     = MODE_WAITING;
          last_err_d = '0;
          retries_d  = '0;
          last_upd_d = item_i.now_ms;
          conv       = 1'b1;
        end
      end
      FUNC_STOP: begin
        mode_d = MODE_STOPPED;
      end
      FUNC_PROBE: begin
        slow_d = 1'b1;
        if (item_i.sensor_found) begin
          mode_d = MODE_STOPPED;
          res_d  = RES_9;
          wres   = 1'b1;
        end else begin
          mode_d = MODE_ERROR;
        end
      end
      default: begin
        case (mode_q)
          MODE_WAITING: begin
            if (conv_due) begin
              mode_d     = MODE_READING;
              last_upd_d = item_i.now_ms;
            end
          end
          MODE_READING: begin
            if (item_i.reading == TEMP_DISCONNECTED) begin
              mode_d = MODE_ERROR;
            end else begin
              temp_d = item_i.reading;
              if (res_q == RES_9) begin
                res_d = RES_12;
                wres  = 1'b1;
              end
              last_err_d = '0;
              retries_d  = '0;
              last_upd_d = item_i.now_ms;
              conv       = 1'b1;
              mode_d     = MODE_WAITING;
            end
          end
          MODE_ERROR: begin
            if (err_due) begin
              if (item_i.sensor_found) begin
                res_d      = RES_10;
                wres       = 1'b1;
                mode_d     = MODE_WAITING;
                last_err_d = '0;
                retries_d  = '0;
                last_upd_d = item_i.now_ms;
                conv       = 1'b1;
              end else begin
                retries_d  = retries_inc;
                last_err_d = item_i.now_ms;
                if (retries_inc >= max_retries_q) begin
                  mode_d = MODE_STOPPED;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_STOPPED;
      last_upd_q <= '0;
      last_err_q <= '0;
      retries_q  <= '0;
      res_q      <= RES_9;
      temp_q     <= '0;
    end else if (step) begin
      mode_q     <= mode_d;
      last_upd_q <= last_upd_d;
      last_err_q <= last_err_d;
      retries_q  <= retries_d;
      res_q      <= res_d;
      temp_q     <= temp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q        <= 1'b1;
      retry_delay_q <= RETRY_DELAY_RST;
      max_retries_q <= MAX_RETRIES_RST;
    end else if (step) begin
      slow_q <= slow_d;
    end else if (cfg_wr) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_SLOW_POLLING: slow_q        <= cfg_i.data[0];
        CFG_RETRY_DELAY:  retry_delay_q <= cfg_i.data;
        CFG_MAX_RETRIES:  max_retries_q <= cfg_i.data[RETRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign res_o.mode             = mode_d;
  assign res_o.temperature      = temp_d;
  assign res_o.resolution_bits  = res_d;
  assign res_o.start_conversion = conv;
  assign res_o.write_resolution = wres;
  assign res_o.retry_count      = retries_d;

  `include "temp_sensor_poll_sequencer_assert.svh"

  `TSPS_ASSERT_NOW(a_res_legal, 1'b1, res_q == RES_9 || res_q == RES_10 || res_q == RES_12, "resolution outside 9, 10, 12")
  `TSPS_ASSERT_NEXT(a_conv_stamp, step && conv, last_upd_q == $past(item_i.now_ms) && retries_q == '0 && mode_q == MODE_WAITING, "conversion request did not restart wait")
  `TSPS_ASSERT_NEXT(a_mode_hold, !step, $stable(mode_q) && $stable(retries_q), "state moved without a transaction")
  `TSPS_ASSERT_NOW(a_wres_res, step && wres, res_d != res_q || item_i.func == FUNC_PROBE || mode_q == MODE_ERROR, "resolution write without a change")

endmodule

/* design/tsps_out_reg.sv */
// ----------------------------------------------------------------------------
// tsps_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module tsps_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tsps_pkg::stage_ctrl_t ctrl_i,
  input  tsps_pkg::out_item_t   res_i,
  output logic                  can_load_o,
  tsps_out_if.source            out_o
);
  import tsps_pkg::*;

  logic      valid_q, valid_d;
  out_item_t res_q;

  assign can_load_o = !valid_q || out_o.ready;
  assign valid_d    = ctrl_i.advance || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.mode             = res_q.mode;
  assign out_o.temperature      = res_q.temperature;
  assign out_o.resolution_bits  = res_q.resolution_bits;
  assign out_o.start_conversion = res_q.start_conversion;
  assign out_o.write_resolution = res_q.write_resolution;
  assign out_o.retry_count      = res_q.retry_count;

endmodule

/* design/temp_sensor_poll_sequencer.sv */
// ----------------------------------------------------------------------------
// temp_sensor_poll_sequencer
// Polling sequencer for a temperature sensor: one result per command.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       payload
//  in_i     in   valid/ready     func, now_ms, sensor_found, reading
//  out_o    out  valid/ready     mode, temperature, resolution_bits,
//                                start_conversion, write_resolution, retry_count
//  cfg_i    in   valid/ready     index, data (ready low while a command is held)
//
//  One command per cycle sustained while results are taken; a result passes through
//  the input register, then update logic into the result register.
//  State is updated as the command leaves the input register.
//  A stalled result stalls the input register; ready is low only when both are full.
//  Reset is asynchronous and sets state, config and valid flags to their defaults.
// ----------------------------------------------------------------------------
module temp_sensor_poll_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsps_in_if.sink    in_i,
  tsps_out_if.source out_o,
  tsps_cfg_if.sink   cfg_i
);
  import tsps_pkg::*;

  stage_ctrl_t ctrl;
  in_item_t    item;
  out_item_t   res;
  logic        can_load;

  tsps_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .can_load_i (can_load),
    .ctrl_o     (ctrl),
    .item_o     (item)
  );

  tsps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .ctrl_i (ctrl),
    .item_i (item),
    .res_o  (res)
  );

  tsps_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule
